FILE: rtl/core/dcp_pkg.sv
// Package for the decimal centi parser: parse phases, character codes,
// limits and the record passed from the parse stage to the result stage.
// No dependencies.
package dcp_pkg;

  localparam int unsigned IntW   = 14;
  localparam int unsigned FracW  = 7;
  localparam int unsigned CntW   = 2;
  localparam int unsigned MagW   = 20;
  localparam int unsigned ValueW = 18;

  localparam logic [IntW-1:0] LimitInt = IntW'(1000);
  localparam logic [MagW-1:0] LimitMag = MagW'(100000);

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_SIGN = 3'd1,
    PH_INT  = 3'd2,
    PH_FRAC = 3'd3,
    PH_TAIL = 3'd4,
    PH_FAIL = 3'd5
  } phase_e;

  // Snapshot of a finished string, handed to the result stage.
  typedef struct packed {
    logic             parsed;    // ended in integer, fraction or tail phase
    logic             negative;
    logic [IntW-1:0]  int_part;
    logic [FracW-1:0] frac_val;  // fraction already scaled to hundredths
  } parse_done_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

endpackage

FILE: rtl/core/decimal_centi_parser.sv
// Top level of the streaming decimal parser: input register, handshake and
// assertions. Depends on dcp_pkg, dcp_parse and dcp_result.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------
//   input   | in        | in_valid_i / in_stall_o | char_code_i, is_last_i
//   output  | out       | out_valid_o / out_stall_i | ok_o, value_o
//
// One character per cycle while no final character waits for the finish register;
// the parse state loop closes around dcp_parse through the parse state registers.
// A taken final character moves through the input, finish and output registers in order.
// Reset clears all control state and returns the parser to blank skipping.
// A stall on the output holds the output register, then the finish register,
// then a pending final character; other characters keep flowing.
module decimal_centi_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        char_code_i,
  input  logic                              is_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [dcp_pkg::ValueW-1:0] value_o
);
  import dcp_pkg::*;

  // Input register: one character request waiting to be parsed.
  logic        a_valid_q;
  logic [7:0]  a_char_q;
  logic        a_last_q;
  logic        a_adv;
  logic        in_accept;
  logic        fin_ready;
  parse_done_t done;

  // A final character must find room in the finish register; others
  // only update the parse state and never wait.
  assign a_adv      = a_valid_q && (!a_last_q || fin_ready);
  assign in_stall_o = a_valid_q && !a_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_accept) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  // Capture the payload with the request.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_char_q <= char_code_i;
      a_last_q <= is_last_i;
    end
  end

  dcp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (a_adv),
    .char_code_i (a_char_q),
    .is_last_i   (a_last_q),
    .done_o      (done)
  );

  dcp_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .done_valid_i (a_adv && a_last_q),
    .done_i       (done),
    .fin_ready_o  (fin_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .value_o      (value_o)
  );

`ifndef NO_ASSERTIONS
  // A failed parse reports zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (value_o == '0))
    else $error("failed parse with nonzero value");

  // A good parse stays within the magnitude limit.
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ok_o) |->
      (value_o <= 18'sd100000) && (value_o >= -18'sd100000))
    else $error("parsed value out of range");

  // Only a pending final character can hold off new requests.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_valid_q && a_last_q && !fin_ready))
    else $error("input stalled without a blocked final character");

  // A final character that leaves behind a stalled output fills the finish
  // stage, which then takes the next final one only once the output moves.
  a_fin_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_last_q && out_valid_o && out_stall_i) |=> (fin_ready == !out_stall_i))
    else $error("finish stage lost a result");
`endif

endmodule

FILE: rtl/core/dcp_parse.sv
// Character parse stage: holds the running parse state and advances it by
// one character per step. Depends on dcp_pkg.
module dcp_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           char_code_i,
  input  logic                 is_last_i,
  output dcp_pkg::parse_done_t done_o
);
  import dcp_pkg::*;

  phase_e           phase_q, phase_d;
  logic             negative_q, negative_d;
  logic [IntW-1:0]  int_part_q, int_part_d;
  logic [FracW-1:0] frac_part_q, frac_part_d;
  logic [CntW-1:0]  frac_count_q, frac_count_d;
  logic [3:0]       digit;
  logic             char_digit;
  logic [IntW-1:0]  int_shift;

  assign digit      = 4'(char_code_i - CharZero);
  assign char_digit = is_digit(char_code_i);
  // int_part stays at or below the limit here, so the sum never wraps
  assign int_shift  = IntW'(int_part_q * IntW'(10) + IntW'(digit));

  always_comb begin
    phase_d      = phase_q;
    negative_d   = negative_q;
    int_part_d   = int_part_q;
    frac_part_d  = frac_part_q;
    frac_count_d = frac_count_q;
    case (phase_q)
      PH_LEAD, PH_SIGN: begin
        if (phase_q == PH_LEAD && (char_code_i == CharSpace || char_code_i == CharTab)) begin
          phase_d = PH_LEAD;
        end else if (phase_q == PH_LEAD &&
                     (char_code_i == CharPlus || char_code_i == CharMinus)) begin
          negative_d = (char_code_i == CharMinus);
          phase_d    = PH_SIGN;
        end else if (char_digit) begin
          if (int_part_q > LimitInt) begin
            phase_d = PH_FAIL;
          end else begin
            phase_d    = PH_INT;
            int_part_d = int_shift;
          end
        end else begin
          phase_d = PH_FAIL;
        end
      end
      PH_INT: begin
        if (char_digit) begin
          if (int_part_q > LimitInt) phase_d = PH_FAIL;
          else                       int_part_d = int_shift;
        end else if (char_code_i == CharPoint) begin
          phase_d = PH_FRAC;
        end else begin
          phase_d = PH_TAIL;
        end
      end
      PH_FRAC: begin
        if (char_digit) begin
          if (frac_count_q < CntW'(2)) begin
            frac_part_d  = FracW'(frac_part_q * FracW'(10) + FracW'(digit));
            frac_count_d = frac_count_q + CntW'(1);
          end
        end else begin
          phase_d = PH_TAIL;
        end
      end
      PH_TAIL: phase_d = PH_TAIL;
      default: phase_d = PH_FAIL;
    endcase
  end

  always_comb begin
    done_o.parsed   = (phase_d == PH_INT) || (phase_d == PH_FRAC) || (phase_d == PH_TAIL);
    done_o.negative = negative_d;
    done_o.int_part = int_part_d;
    case (frac_count_d)
      2'd0:    done_o.frac_val = '0;
      2'd1:    done_o.frac_val = FracW'(frac_part_d * FracW'(10));
      default: done_o.frac_val = frac_part_d;
    endcase
  end

  // Drop back to the blank-skipping state after the final character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      negative_q   <= 1'b0;
      int_part_q   <= '0;
      frac_part_q  <= '0;
      frac_count_q <= '0;
    end else if (step_i) begin
      if (is_last_i) begin
        phase_q      <= PH_LEAD;
        negative_q   <= 1'b0;
        int_part_q   <= '0;
        frac_part_q  <= '0;
        frac_count_q <= '0;
      end else begin
        phase_q      <= phase_d;
        negative_q   <= negative_d;
        int_part_q   <= int_part_d;
        frac_part_q  <= frac_part_d;
        frac_count_q <= frac_count_d;
      end
    end
  end

endmodule

FILE: rtl/core/dcp_result.sv
// Result stage: holds a finished string, forms the magnitude in hundredths,
// checks the limit and drives the output register. Depends on dcp_pkg.
module dcp_result (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       done_valid_i,
  input  dcp_pkg::parse_done_t       done_i,
  output logic                       fin_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic signed [dcp_pkg::ValueW-1:0] value_o
);
  import dcp_pkg::*;

  logic               fin_valid_q;
  parse_done_t        fin_q;
  logic               out_valid_q;
  logic               ok_q, ok_d;
  logic [ValueW-1:0]  value_q, value_d;
  logic               out_ready, fin_adv;
  logic [MagW-1:0]    mag;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign fin_adv     = fin_valid_q && out_ready;
  assign fin_ready_o = !fin_valid_q || out_ready;

  assign mag  = MagW'(fin_q.int_part) * MagW'(100) + MagW'(fin_q.frac_val);
  assign ok_d = fin_q.parsed && (mag <= LimitMag);

  always_comb begin
    if (!ok_d)                 value_d = '0;
    else if (fin_q.negative)   value_d = ValueW'(-mag[ValueW-1:0]);
    else                       value_d = mag[ValueW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (done_valid_i)  fin_valid_q <= 1'b1;
      else if (fin_adv)  fin_valid_q <= 1'b0;
      if (fin_adv)        out_valid_q <= 1'b1;
      else if (out_ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_valid_i) fin_q <= done_i;
    if (fin_adv) begin
      ok_q    <= ok_d;
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign value_o     = signed'(value_q);

endmodule
